/* rtl/arrival_median_tracker_macros.svh */
// Assertion helpers for the arrival median tracker.
// Each checker samples on clk_i and is switched off while rst_ni is low.
`ifndef ARRIVAL_MEDIAN_TRACKER_MACROS_SVH
`define ARRIVAL_MEDIAN_TRACKER_MACROS_SVH

`ifndef ASSERT_OFF

// Check that a property holds at every clock edge.
`define AMT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define AMT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`else

`define AMT_ASSERT(lbl, prop, msg)
`define AMT_ASSERT_IMPL(lbl, ante, cons, msg)

`endif

`endif

/* rtl/amt_pkg.sv */
`default_nettype none

package amt_pkg;

  localparam int RING_ENTRIES = 120;
  localparam int WINDOW_LEN   = 59;
  localparam int HALF_WIN     = WINDOW_LEN / 2;
  localparam int IDX_W        = $clog2(RING_ENTRIES);
  localparam int CNT_W        = IDX_W;
  // signed width for ring position arithmetic before the wrap
  localparam int POS_W        = IDX_W + 3;
  localparam int LEAD_W       = 8;
  localparam int TIME_W       = 64;
  localparam int CFG_W        = 30;
  localparam int CFG_IDX_W    = 1;
  localparam int PROD_W       = CFG_W + 1 + LEAD_W;

  localparam logic signed [LEAD_W-1:0] LEAD_MAX   = LEAD_W'(60);
  localparam logic signed [LEAD_W-1:0] LEAD_MIN   = -LEAD_W'(60);
  localparam logic signed [LEAD_W-1:0] LEAD_RESET = -LEAD_W'(1);

  localparam logic [CFG_W-1:0] FRAME_PERIOD_RESET   = CFG_W'(33333333);
  localparam logic [CFG_W-1:0] JUMP_THRESHOLD_RESET = CFG_W'(3000000);

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_PERIOD   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_JUMP_THRESHOLD = CFG_IDX_W'(1);

  typedef logic signed [TIME_W-1:0] time_t;

  localparam time_t SENTINEL = {1'b0, {(TIME_W-1){1'b1}}};

  typedef enum logic [1:0] {
    ACT_ARRIVAL = 2'd0,
    ACT_TICK    = 2'd1,
    ACT_FILL    = 2'd2
  } action_e;

  typedef struct packed {
    logic clear;
    logic sample;
  } scan_ctl_t;

  typedef struct packed {
    logic [CNT_W-1:0] lt;
    logic [CNT_W-1:0] le;
    time_t            down;
    time_t            up;
  } scan_res_t;

endpackage

`default_nettype wire

/* rtl/amt_ifs.sv */
`default_nettype none

interface amt_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          action;
  logic signed [amt_pkg::TIME_W-1:0]   time_value;

  modport source (output valid, output action, output time_value, input ready);
  modport sink (input valid, input action, input time_value, output ready);
endinterface

interface amt_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [amt_pkg::TIME_W-1:0]   median_time;
  logic                                median_valid;
  logic                                woke;
  logic                                moved;
  logic                                jumped;

  modport source (output valid, output median_time, output median_valid,
                  output woke, output moved, output jumped, input ready);
  modport sink (input valid, input median_time, input median_valid,
                input woke, input moved, input jumped, output ready);
endinterface

`default_nettype wire

/* rtl/amt_ram.sv */
`default_nettype none

module amt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 120
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/amt_scan.sv */
`default_nettype none

// Accumulate order statistics of a window against the current median.
module amt_scan (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire amt_pkg::scan_ctl_t  ctl_i,
  input  wire amt_pkg::time_t      sample_i,
  input  wire amt_pkg::time_t      median_i,
  output amt_pkg::scan_res_t       res_o
);

  amt_pkg::scan_res_t res_q;
  logic below;
  logic above;

  assign below = sample_i < median_i;
  assign above = median_i < sample_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q.lt   <= '0;
      res_q.le   <= '0;
      res_q.down <= '0;
      res_q.up   <= amt_pkg::SENTINEL;
    end else if (ctl_i.clear) begin
      res_q.lt   <= '0;
      res_q.le   <= '0;
      res_q.down <= '0;
      res_q.up   <= amt_pkg::SENTINEL;
    end else if (ctl_i.sample) begin
      if (below) begin
        res_q.lt <= res_q.lt + 1'b1;
        res_q.le <= res_q.le + 1'b1;
        if (res_q.down < sample_i) begin
          res_q.down <= sample_i;
        end
      end else if (above) begin
        if (sample_i < res_q.up) begin
          res_q.up <= sample_i;
        end
      end else begin
        res_q.le <= res_q.le + 1'b1;
      end
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

/* rtl/arrival_median_tracker.sv */
// One item at a time: the input is ready only while idle, so a new item is not accepted
//   until the previous one has raised its result beat. An arrival that leaves the lead
//   positive skips the rescan; an awake tick or any other arrival rescans a window of 59
//   entries (0..119 when the lead is at most zero); a fill first sweeps all 120 entries.
// Reset: asynchronous, active low; a clearing pass then zeroes all 120 entries of the ring
//   with the input held not ready (configuration writes are taken throughout).
`default_nettype none
`include "arrival_median_tracker_macros.svh"

module arrival_median_tracker (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [amt_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [amt_pkg::CFG_W-1:0]       cfg_wdata_i,
  amt_in_if.sink                               in_i,
  amt_out_if.source                            out_o
);

  typedef enum logic [3:0] {
    S_SWEEP,
    S_IDLE,
    S_ARR_MUL,
    S_ARR_WR,
    S_SETUP,
    S_SCAN,
    S_DRAIN,
    S_DECIDE,
    S_FLAGS,
    S_DONE
  } state_e;

  localparam logic signed [amt_pkg::POS_W-1:0] RING_S =
    amt_pkg::POS_W'(amt_pkg::RING_ENTRIES);
  localparam logic [amt_pkg::IDX_W-1:0] LAST_IDX =
    amt_pkg::IDX_W'(amt_pkg::RING_ENTRIES - 1);

  state_e state_q;

  // Configuration
  logic [amt_pkg::CFG_W-1:0] period_q;
  logic [amt_pkg::CFG_W-1:0] thresh_q;

  // Tracker state. The ring holds times relative to base_q, so a tick only
  // advances the base instead of touching all entries.
  logic [amt_pkg::TIME_W-1:0]        base_q;
  logic [amt_pkg::IDX_W-1:0]         wi_q;
  logic signed [amt_pkg::LEAD_W-1:0] lead_q;
  amt_pkg::time_t                    med_q;
  amt_pkg::time_t                    old_q;

  // Per-item working registers
  logic [1:0]                        act_q;
  logic                              asleep_q;
  amt_pkg::time_t                    tvb_q;
  logic signed [amt_pkg::PROD_W-1:0] prod_q;
  logic [amt_pkg::TIME_W-1:0]        sweep_val_q;
  logic [amt_pkg::IDX_W-1:0]         sw_idx_q;
  logic                              clr_q;
  logic                              moved_q;
  logic                              jump_q;

  // Scan sequencing
  logic [amt_pkg::IDX_W-1:0] rd_idx_q;
  logic [amt_pkg::CNT_W-1:0] cnt_q;
  logic [amt_pkg::CNT_W-1:0] issued_q;
  logic                      rd_v_q;
  logic                      sum_v_q;
  amt_pkg::time_t            sum_q;

  // Result beat
  logic           out_valid_q;
  amt_pkg::time_t o_med_q;
  logic           o_mvalid_q;
  logic           o_woke_q;
  logic           o_moved_q;
  logic           o_jump_q;

  // Ring memory port
  logic                       ram_we;
  logic [amt_pkg::IDX_W-1:0]  ram_waddr;
  logic [amt_pkg::TIME_W-1:0] ram_wdata;
  logic [amt_pkg::IDX_W-1:0]  ram_raddr;
  logic [amt_pkg::TIME_W-1:0] ram_rdata;

  amt_pkg::scan_ctl_t scan_ctl;
  amt_pkg::scan_res_t scan_res;

  logic in_fire;
  logic issue;
  logic out_free;

  logic signed [amt_pkg::POS_W-1:0] start_pos;
  logic signed [amt_pkg::POS_W-1:0] span;
  logic [amt_pkg::IDX_W-1:0]        start_idx;
  logic [amt_pkg::CNT_W-1:0]        win_cnt;

  amt_pkg::time_t             new_med;
  logic [amt_pkg::TIME_W-1:0] mag;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign issue      = (state_q == S_SCAN) && (issued_q != cnt_q);
  assign out_free   = !out_valid_q || out_o.ready;

  assign out_o.valid        = out_valid_q;
  assign out_o.median_time  = o_med_q;
  assign out_o.median_valid = o_mvalid_q;
  assign out_o.woke         = o_woke_q;
  assign out_o.moved        = o_moved_q;
  assign out_o.jumped       = o_jump_q;

  // Window placement: start = (write index - lead - window) mod ring.
  // With a positive lead the window is fixed length; otherwise it ends at
  // the write index and may be empty or wrap nearly the whole ring.
  always_comb begin
    start_pos = $signed({3'b000, wi_q}) - amt_pkg::POS_W'(lead_q)
                - amt_pkg::POS_W'(amt_pkg::WINDOW_LEN);
    if (start_pos < 0) start_pos = start_pos + RING_S;
    if (start_pos < 0) start_pos = start_pos + RING_S;
    if (start_pos >= RING_S) start_pos = start_pos - RING_S;
    start_idx = start_pos[amt_pkg::IDX_W-1:0];
    span = $signed({3'b000, wi_q}) - start_pos;
    if (span < 0) span = span + RING_S;
    if (lead_q <= 0) begin
      win_cnt = span[amt_pkg::CNT_W-1:0];
    end else begin
      win_cnt = amt_pkg::CNT_W'(amt_pkg::WINDOW_LEN);
    end
  end

  // Median step: too few at or below moves up, too many below moves down.
  always_comb begin
    if (scan_res.le <= amt_pkg::CNT_W'(amt_pkg::HALF_WIN)) begin
      new_med = scan_res.up;
    end else if (scan_res.lt > amt_pkg::CNT_W'(amt_pkg::HALF_WIN)) begin
      new_med = scan_res.down;
    end else begin
      new_med = med_q;
    end
  end

  // Step magnitude as the true distance; it always fits in 64 bits unsigned.
  assign mag = (med_q < old_q) ? (old_q - med_q) : (med_q - old_q);

  // Ring port: sweep and arrival write, scan reads.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wi_q;
    ram_wdata = tvb_q - amt_pkg::TIME_W'(prod_q);
    ram_raddr = rd_idx_q;
    unique case (state_q)
      S_SWEEP: begin
        ram_we    = 1'b1;
        ram_waddr = sw_idx_q;
        ram_wdata = sweep_val_q;
      end
      S_ARR_WR: begin
        ram_we = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  assign scan_ctl.clear  = (state_q == S_SETUP);
  assign scan_ctl.sample = sum_v_q;

  amt_ram #(
    .WIDTH (amt_pkg::TIME_W),
    .DEPTH (amt_pkg::RING_ENTRIES)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  amt_scan u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (scan_ctl),
    .sample_i (sum_q),
    .median_i (med_q),
    .res_o    (scan_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_SWEEP;
      period_q    <= amt_pkg::FRAME_PERIOD_RESET;
      thresh_q    <= amt_pkg::JUMP_THRESHOLD_RESET;
      base_q      <= '0;
      wi_q        <= '0;
      lead_q      <= amt_pkg::LEAD_RESET;
      med_q       <= '0;
      old_q       <= '0;
      act_q       <= '0;
      asleep_q    <= 1'b0;
      sweep_val_q <= '0;
      sw_idx_q    <= '0;
      clr_q       <= 1'b1;
      moved_q     <= 1'b0;
      jump_q      <= 1'b0;
      rd_idx_q    <= '0;
      cnt_q       <= '0;
      issued_q    <= '0;
      rd_v_q      <= 1'b0;
      sum_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == amt_pkg::CFG_FRAME_PERIOD) begin
          period_q <= cfg_wdata_i;
        end else if (cfg_idx_i == amt_pkg::CFG_JUMP_THRESHOLD) begin
          thresh_q <= cfg_wdata_i;
        end
      end

      // Raise the result beat when an item finishes; drop it once taken.
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      // Read pipeline: address, registered data, rebased sample.
      rd_v_q  <= issue;
      sum_v_q <= rd_v_q;

      unique case (state_q)
        S_SWEEP: begin
          if (sw_idx_q == LAST_IDX) begin
            sw_idx_q <= '0;
            clr_q    <= 1'b0;
            state_q  <= clr_q ? S_IDLE : S_SETUP;
          end else begin
            sw_idx_q <= sw_idx_q + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            act_q    <= in_i.action;
            asleep_q <= (med_q == amt_pkg::SENTINEL);
            moved_q  <= 1'b0;
            jump_q   <= 1'b0;
            priority case (in_i.action)
              amt_pkg::ACT_ARRIVAL: begin
                if (lead_q < amt_pkg::LEAD_MAX) lead_q <= lead_q + 1'b1;
                state_q <= S_ARR_MUL;
              end
              amt_pkg::ACT_TICK: begin
                if (med_q == amt_pkg::SENTINEL) begin
                  // sleeping tick: hold everything
                  state_q <= S_DONE;
                end else begin
                  if (lead_q > amt_pkg::LEAD_MIN) lead_q <= lead_q - 1'b1;
                  base_q  <= base_q + amt_pkg::TIME_W'(period_q);
                  med_q   <= med_q + amt_pkg::TIME_W'(period_q);
                  state_q <= S_SETUP;
                end
              end
              amt_pkg::ACT_FILL: begin
                // rebase to zero so the sweep stores the fill value as is
                base_q      <= '0;
                sweep_val_q <= in_i.time_value;
                sw_idx_q    <= '0;
                state_q     <= S_SWEEP;
              end
              default: begin
                state_q <= S_DONE;
              end
            endcase
          end
        end
        S_ARR_MUL: begin
          prod_q <= $signed({1'b0, period_q}) * lead_q;
          state_q <= S_ARR_WR;
        end
        S_ARR_WR: begin
          wi_q    <= (wi_q == LAST_IDX) ? '0 : wi_q + 1'b1;
          state_q <= (lead_q <= 0) ? S_SETUP : S_DONE;
        end
        S_SETUP: begin
          rd_idx_q <= start_idx;
          cnt_q    <= win_cnt;
          issued_q <= '0;
          state_q  <= S_SCAN;
        end
        S_SCAN: begin
          if (issue) begin
            rd_idx_q <= (rd_idx_q == LAST_IDX) ? '0 : rd_idx_q + 1'b1;
            issued_q <= issued_q + 1'b1;
          end else begin
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!rd_v_q && !sum_v_q) state_q <= S_DECIDE;
        end
        S_DECIDE: begin
          old_q   <= med_q;
          med_q   <= new_med;
          moved_q <= (new_med != med_q);
          state_q <= S_FLAGS;
        end
        S_FLAGS: begin
          jump_q  <= mag > amt_pkg::TIME_W'(thresh_q);
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Payload registers; hold the rebased stamp from the accepted beat.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      tvb_q <= in_i.time_value - base_q;
    end
    sum_q <= ram_rdata + base_q;
    if (state_q == S_DONE && out_free) begin
      o_med_q    <= med_q;
      o_mvalid_q <= (med_q != amt_pkg::SENTINEL);
      o_woke_q   <= (act_q == amt_pkg::ACT_ARRIVAL) && asleep_q
                    && (med_q != amt_pkg::SENTINEL);
      o_moved_q  <= moved_q;
      o_jump_q   <= jump_q;
    end
  end

  // Checks
  `AMT_ASSERT(a_lead_range, (lead_q >= amt_pkg::LEAD_MIN && lead_q <= amt_pkg::LEAD_MAX), "lead out of range")
  `AMT_ASSERT_IMPL(a_no_wr_scan, (state_q == S_SCAN || state_q == S_DRAIN), !ram_we, "ring write during scan")
  `AMT_ASSERT_IMPL(a_sum_pipe, sum_v_q, $past(rd_v_q), "sample without a read")
  `AMT_ASSERT_IMPL(a_jump_moved, out_valid_q, (!o_jump_q || o_moved_q), "jump flag without a move")

endmodule

`default_nettype wire

/* tb/arrival_median_tracker_tb.sv */
`timescale 1ns / 100ps

module arrival_median_tracker_tb;
  import amt_pkg::*;

  // Out-of-range action code: the block must leave its state alone and report.
  localparam logic [1:0] ACT_UNKNOWN = 2'd3;
  localparam time_t TIME_MIN = {1'b1, {(TIME_W-1){1'b0}}};

  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 107;
  // Worst item: 120-entry fill sweep plus a 119-entry scan and overhead.
  localparam int DRAIN_CYCLES    = 300;
  localparam int CYCLE_LIMIT     = 2000000;
  localparam int DIR_ROWS        = 22;

  typedef struct packed {
    time_t median;
    logic  valid;
    logic  woke;
    logic  moved;
    logic  jumped;
  } median_result_t;

  typedef struct packed {
    logic [1:0]     act;
    time_t          value;
    logic           typed;
    median_result_t want;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;

  amt_in_if  in_bus ();
  amt_out_if out_bus ();

  arrival_median_tracker u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_bus.sink),
    .out_o       (out_bus.source)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the ring, write pointer, lead counter,
  // median and both configuration registers.
  // ---------------------------------------------------------------------------
  time_t            ring_model [RING_ENTRIES];
  int               wr_idx;
  int               lead;
  time_t            median_est;
  logic [CFG_W-1:0] period_cfg;
  logic [CFG_W-1:0] thresh_cfg;

  median_result_t pending_medians [$];
  int             mismatch_count = 0;
  int             counted_items;
  int             cycle_count = 0;
  bit             calm;
  dir_row_t       dir_rows [DIR_ROWS];

  always @(posedge clk) cycle_count <= cycle_count + 1;

  function automatic int wrap_ring(input int v);
    int r;
    r = v % RING_ENTRIES;
    if (r < 0) r += RING_ENTRIES;
    return r;
  endfunction

  // Mostly back-to-back; a few short gaps and the odd long one. In a calm
  // stretch both sides run without any gap at all.
  function automatic int pick_delay();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  // Scan the window placed by the lead and step the median one entry down or
  // up. The window always ends at the write pointer when the lead is at most
  // zero, so it shrinks as the lead falls and is empty at lead -59.
  task automatic rescan_window(output logic moved, output logic jump);
    int          start_pos;
    int          stop_pos;
    int          span;
    int          lt_cnt;
    int          le_cnt;
    int          pos;
    time_t       down;
    time_t       up;
    time_t       prev;
    time_t       entry;
    logic [63:0] mag;
    start_pos = wrap_ring(wr_idx - lead - WINDOW_LEN);
    stop_pos  = (lead <= 0) ? wr_idx : wrap_ring(start_pos + WINDOW_LEN);
    span      = wrap_ring(stop_pos - start_pos);
    lt_cnt    = 0;
    le_cnt    = 0;
    down      = '0;
    up        = SENTINEL;
    prev      = median_est;
    pos       = start_pos;
    moved     = 1'b0;
    jump      = 1'b0;
    for (int i = 0; i < span; i++) begin
      entry = ring_model[pos];
      if (entry < median_est) begin
        lt_cnt++;
        le_cnt++;
        // the step down never goes below zero
        if (entry > down) down = entry;
      end else if (entry > median_est) begin
        if (entry < up) up = entry;
      end else begin
        le_cnt++;
      end
      pos = (pos + 1) % RING_ENTRIES;
    end
    if (le_cnt <= HALF_WIN) begin
      median_est = up;
    end else if (lt_cnt > HALF_WIN) begin
      median_est = down;
    end else begin
      return;
    end
    // true distance: the unsigned difference of the larger minus the smaller
    if (median_est < prev) mag = prev - median_est;
    else mag = median_est - prev;
    jump  = mag > {{(64-CFG_W){1'b0}}, thresh_cfg};
    moved = median_est != prev;
  endtask

  // Advance the predictor by one input beat and return the result it expects.
  task automatic track_median(input logic [1:0] act, input time_t value,
                              output median_result_t res);
    time_t prod;
    logic  asleep;
    logic  moved;
    logic  jump;
    logic  woke;
    moved   = 1'b0;
    jump    = 1'b0;
    woke    = 1'b0;
    case (act)
      ACT_ARRIVAL: begin
        if (lead < LEAD_MAX) lead++;
        prod = $signed({{(64-CFG_W){1'b0}}, period_cfg}) * time_t'(lead);
        ring_model[wr_idx] = value - prod;
        wr_idx = (wr_idx + 1) % RING_ENTRIES;
        if (lead <= 0) begin
          asleep = median_est == SENTINEL;
          rescan_window(moved, jump);
          woke = asleep && (median_est != SENTINEL);
        end
      end
      ACT_TICK: begin
        // a sleeping median ignores ticks entirely, lead included
        if (median_est != SENTINEL) begin
          if (lead > LEAD_MIN) lead--;
          foreach (ring_model[i]) ring_model[i] = ring_model[i] + period_cfg;
          median_est = median_est + period_cfg;
          rescan_window(moved, jump);
        end
      end
      ACT_FILL: begin
        foreach (ring_model[i]) ring_model[i] = value;
        rescan_window(moved, jump);
      end
      default: begin
        // unknown action: state stays as it is
        moved = 1'b0;
      end
    endcase
    res.median = median_est;
    res.valid  = median_est != SENTINEL;
    res.woke   = woke;
    res.moved  = moved;
    res.jumped = jump;
  endtask

  task automatic flag_mismatch(input string field, input logic [63:0] got,
                               input logic [63:0] want);
    $display("%0t ns: %s is %h, predicted %h", $time, field, got, want);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Input side: drive at the falling edge, take the beat at the rising edge
  // where valid and ready meet, then record what the block owes us.
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic [1:0] act, input time_t value,
                           input logic typed, input median_result_t want);
    median_result_t predicted;
    int             gap;
    gap = pick_delay();
    repeat (gap) begin
      @(negedge clk);
      in_bus.valid <= 1'b0;
    end
    @(negedge clk);
    in_bus.valid      <= 1'b1;
    in_bus.action     <= act;
    in_bus.time_value <= value;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    track_median(act, value, predicted);
    // Typed rows still run the predictor so its state stays in step.
    pending_medians.push_back(typed ? want : predicted);
    counted_items++;
  endtask

  // Drop valid, let every owed beat come back, then let the block settle.
  task automatic wait_idle();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (pending_medians.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_FRAME_PERIOD) period_cfg = data;
    else thresh_cfg = data;
  endtask

  function automatic time_t draw_jitter();
    time_t p64;
    int    r;
    p64 = $signed({{(64-CFG_W){1'b0}}, period_cfg});
    r = $urandom_range(0, 9);
    if (r < 6) return time_t'($urandom_range(0, period_cfg / 4)) - time_t'(period_cfg / 8);
    if (r < 9) return time_t'($urandom_range(0, 8)) * p64 - 4 * p64;
    return time_t'($signed($urandom));
  endfunction

  // Starting stamp of a stream: near zero (where the step down clamps), large
  // positive, negative, just below the top so the sums wrap, or anything.
  function automatic time_t draw_base();
    time_t p64;
    int    r;
    p64 = $signed({{(64-CFG_W){1'b0}}, period_cfg});
    r = $urandom_range(0, 9);
    if (r < 4) return time_t'($urandom_range(0, 100000));
    if (r < 7) return {16'h0000, 16'($urandom), $urandom};
    if (r < 8) return {16'hFFFF, 16'($urandom), $urandom};
    if (r < 9) return SENTINEL - time_t'($urandom_range(0, 1000)) * p64;
    return {$urandom, $urandom};
  endfunction

  // One stream of arrivals and ticks around a random base. Arrival stamps
  // advance one period per arrival, so the stored times cluster and the
  // median has something to follow. The mode shapes the lead:
  //   balanced      keep the lead near zero
  //   arrival burst drive the lead up into saturation
  //   tick burst    pull the lead down until the median sleeps
  //   sleep/wake    ticks first, then arrivals until the median wakes
  // The stream stops early once the phase has its share of beats.
  task automatic run_session();
    time_t      base;
    time_t      stamp;
    time_t      p64;
    int         len;
    int         mode;
    int         n_arr;
    int         r;
    logic [1:0] act;
    calm  = $urandom_range(0, 4) == 0;
    p64   = $signed({{(64-CFG_W){1'b0}}, period_cfg});
    base  = draw_base();
    n_arr = 0;
    mode  = $urandom_range(0, 9);
    len   = (mode >= 6) ? $urandom_range(40, 75) : $urandom_range(8, 40);
    // most streams start from a filled ring so the median snaps to the base
    if ($urandom_range(0, 3) != 0) send_item(ACT_FILL, base + draw_jitter(), 1'b0, '0);
    for (int k = 0; k < len; k++) begin
      if (counted_items >= ITEMS_PER_PHASE) break;
      r = $urandom_range(0, 99);
      if (r < 7) begin
        // noise: any action code, any bits
        send_item(2'($urandom_range(0, 3)), {$urandom, $urandom}, 1'b0, '0);
      end else begin
        case (mode)
          6, 7: begin
            act = (r < 90) ? ACT_ARRIVAL : ACT_TICK;
          end
          8: begin
            act = (r < 90) ? ACT_TICK : ACT_ARRIVAL;
          end
          9: begin
            act = (k < len / 2) ? ACT_TICK : ACT_ARRIVAL;
          end
          default: begin
            if (lead > 1) act = ACT_TICK;
            else if (lead < -1) act = ACT_ARRIVAL;
            else act = (r % 2 == 0) ? ACT_ARRIVAL : ACT_TICK;
          end
        endcase
        if (act == ACT_ARRIVAL) begin
          stamp = base + time_t'(n_arr) * p64 + draw_jitter();
          n_arr++;
          send_item(act, stamp, 1'b0, '0);
        end else begin
          // the stamp is unused on a tick; toggle its bits anyway
          send_item(act, {$urandom, $urandom}, 1'b0, '0);
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Output side: stall ready at random, compare each beat with the oldest
  // prediction.
  // ---------------------------------------------------------------------------
  initial begin : ready_drive
    int stall_left;
    stall_left = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        out_bus.ready <= 1'b1;
        stall_left = pick_delay();
      end
    end
  end

  always @(posedge clk) begin : result_check
    median_result_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_medians.size() == 0) begin
        flag_mismatch("beat with nothing pending, median_time", out_bus.median_time, '0);
      end else begin
        want = pending_medians.pop_front();
        if (out_bus.median_time !== want.median)
          flag_mismatch("median_time", out_bus.median_time, want.median);
        if (out_bus.median_valid !== want.valid)
          flag_mismatch("median_valid", 64'(out_bus.median_valid), 64'(want.valid));
        if (out_bus.woke !== want.woke)
          flag_mismatch("woke", 64'(out_bus.woke), 64'(want.woke));
        if (out_bus.moved !== want.moved)
          flag_mismatch("moved", 64'(out_bus.moved), 64'(want.moved));
        if (out_bus.jumped !== want.jumped)
          flag_mismatch("jumped", 64'(out_bus.jumped), 64'(want.jumped));
      end
    end
  end

  // Hard stop if the block hangs; sized from the slowest legal run several times over.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("Mismatches found");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed table under reset configuration, then
  // phases of random streams, each under a fresh register setting.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [CFG_W-1:0] new_period;
    logic [CFG_W-1:0] new_thresh;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = '0;
    cfg_wdata         = '0;
    in_bus.valid      = 1'b0;
    in_bus.action     = ACT_ARRIVAL;
    in_bus.time_value = '0;
    calm              = 1'b0;
    counted_items     = 0;

    foreach (ring_model[i]) ring_model[i] = '0;
    wr_idx     = 0;
    lead       = LEAD_RESET;
    median_est = '0;
    period_cfg = FRAME_PERIOD_RESET;
    thresh_cfg = JUMP_THRESHOLD_RESET;

    // Typed rows are the ones that follow straight from the reset state or
    // from a ring filled with the sentinel.
    dir_rows = '{
      // unknown action straight after reset: median 0, nothing flagged
      '{ACT_UNKNOWN, 64'sd0,     1'b1, '{64'sd0, 1'b1, 1'b0, 1'b0, 1'b0}},
      // fill with zero matches the zero median: kept
      '{ACT_FILL,    64'sd0,     1'b1, '{64'sd0, 1'b1, 1'b0, 1'b0, 1'b0}},
      '{ACT_ARRIVAL, TIME_MIN,   1'b0, '0},
      '{ACT_ARRIVAL, SENTINEL,   1'b0, '0},
      // two ticks on top of the largest stamp wrap it negative
      '{ACT_TICK,    64'sd0,     1'b0, '0},
      '{ACT_TICK,    -64'sd1,    1'b0, '0},
      // everything at the sentinel: the median climbs to it and sleeps
      '{ACT_FILL,    SENTINEL,   1'b1, '{SENTINEL, 1'b0, 1'b0, 1'b1, 1'b1}},
      // sleeping tick changes nothing
      '{ACT_TICK,    64'sd0,     1'b1, '{SENTINEL, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{ACT_UNKNOWN, -64'sd1,    1'b1, '{SENTINEL, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{ACT_ARRIVAL, 64'sd5,     1'b0, '0},
      // all entries far below: the step down clamps at zero
      '{ACT_FILL,    TIME_MIN,   1'b0, '0},
      // small step up, below the jump threshold
      '{ACT_FILL,    64'sd1000,  1'b0, '0},
      '{ACT_TICK,    64'sd0,     1'b0, '0},
      '{ACT_ARRIVAL, 64'sh5555_5555_5555_5555, 1'b0, '0},
      '{ACT_ARRIVAL, 64'shAAAA_AAAA_AAAA_AAAA, 1'b0, '0},
      '{ACT_FILL,    -64'sd1,    1'b0, '0},
      '{ACT_ARRIVAL, 64'sd0,     1'b0, '0},
      '{ACT_FILL,    64'sh7FFF_FFFF_FFFF_FFFE, 1'b0, '0},
      // ring and median wrap past the top together
      '{ACT_TICK,    64'sd0,     1'b0, '0},
      // jump across nearly the whole signed range
      '{ACT_FILL,    64'sh7FFF_FFFF_FFFF_FFF0, 1'b0, '0},
      '{ACT_FILL,    TIME_MIN + 64'sd1, 1'b0, '0},
      '{ACT_UNKNOWN, SENTINEL,   1'b0, '0}
    };

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // the block holds ready low through its clearing pass; send_item waits
    foreach (dir_rows[i])
      send_item(dir_rows[i].act, dir_rows[i].value, dir_rows[i].typed, dir_rows[i].want);

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      case (ph)
        0: begin
          new_period = CFG_W'(1);
          new_thresh = '0;
        end
        1: begin
          new_period = CFG_W'(1000000000);
          new_thresh = CFG_W'(1000000000);
        end
        2: begin
          new_period = FRAME_PERIOD_RESET;
          new_thresh = JUMP_THRESHOLD_RESET;
        end
        3: begin
          new_period = CFG_W'($urandom_range(1, 1000000));
          new_thresh = CFG_W'($urandom_range(0, 100000));
        end
        4: begin
          new_period = CFG_W'(16666667);
          new_thresh = '0;
        end
        6: begin
          new_period = CFG_W'(1);
          new_thresh = CFG_W'(1000000000);
        end
        default: begin
          new_period = CFG_W'($urandom_range(1, 1000000000));
          new_thresh = CFG_W'($urandom_range(0, 1000000000));
        end
      endcase
      write_reg(CFG_FRAME_PERIOD, new_period);
      write_reg(CFG_JUMP_THRESHOLD, new_thresh);
      counted_items = 0;
      while (counted_items < ITEMS_PER_PHASE) run_session();
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/amt_pkg.sv
rtl/amt_ifs.sv
rtl/amt_ram.sv
rtl/amt_scan.sv
rtl/arrival_median_tracker.sv
tb/arrival_median_tracker_tb.sv
